### src/lag_pkg.sv
`timescale 1ns / 1ps

package lag_pkg;

  // Group table size and the widths that follow from it.
  localparam int MAX_GROUPS = 16;
  localparam int GIDX_W     = $clog2(MAX_GROUPS);
  localparam int GCNT_W     = $clog2(MAX_GROUPS + 1);

  // Fixed field widths.
  localparam int THETA_W = 16;
  localparam int TOL_W   = 15;
  localparam int CNT_W   = 10;
  localparam int IDX_W   = 4;

  // Running-mean arithmetic: n * (mean + pi) + theta fits in 27 bits.
  localparam int AEXT_W = THETA_W + 1;
  localparam int NUM_W  = CNT_W + AEXT_W;
  localparam int DEN_W  = CNT_W + 1;

  localparam logic [AEXT_W-1:0] PI_UNITS  = AEXT_W'(65536);
  localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(1023);
  localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(7282);
  localparam logic [GCNT_W-1:0] GROUPS_LIMIT = GCNT_W'(MAX_GROUPS);

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;
  typedef logic [IDX_W-1:0] grp_idx_t;

  typedef struct packed {
    logic [THETA_W-1:0] theta;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    grp_idx_t           group_index;
    logic               new_group;
    logic               dropped;
    logic [THETA_W-1:0] group_mean;
    logic [CNT_W-1:0]   group_size;
  } out_item_t;

  // One group table entry.
  typedef struct packed {
    logic [CNT_W-1:0]   cnt;
    logic [THETA_W-1:0] mean;
  } grp_ent_t;

  typedef struct packed {
    logic start;
    num_t num;
    den_t den;
  } div_req_t;

  typedef struct packed {
    logic done;
    num_t quo;
  } div_rsp_t;

endpackage

### src/lag_ram.sv
`timescale 1ns / 1ps

module lag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/lag_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The quotient is valid in
// the cycle that done is high.
module lag_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lag_pkg::div_req_t req,
  output lag_pkg::div_rsp_t rsp
);

  localparam int REM_W  = lag_pkg::DEN_W + 1;
  localparam int STEP_W = $clog2(lag_pkg::NUM_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  lag_pkg::num_t       acc_r, acc_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  lag_pkg::den_t       den_r, den_nxt;

  logic [REM_W-1:0]    rem_sh;
  logic                qbit;

  always_comb begin
    rem_sh   = {rem_r[REM_W-2:0], acc_r[lag_pkg::NUM_W-1]};
    qbit     = (rem_sh >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(lag_pkg::NUM_W);
      acc_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt  = qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
      acc_nxt  = {acc_r[lag_pkg::NUM_W-2:0], qbit};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = acc_r;

endmodule

### src/line_angle_grouper_core.sv
`timescale 1ns / 1ps

// A line taken by a group goes through the group search, the multiply and the
// 27-step divider before out_valid rises; a line that opens a group or is
// dropped skips the multiply and divider, and one that starts a frame skips the
// search too. One line is in work at a time and the next transfer can be taken as
// soon as out_valid rises; the divider, the group search and out_stall set the rate. Synchronous active-low
// reset empties the group table, clears the output and loads twenty degrees.
module line_angle_grouper_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lag_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lag_pkg::out_item_t                  out_data,
  input  logic                                cfg_wr_en,
  input  logic [lag_pkg::TOL_W-1:0]           cfg_wr_data
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_TEST  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_START = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_NEW   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  localparam int ENT_W = $bits(lag_pkg::grp_ent_t);

  state_t                              state_r, state_nxt;
  logic [lag_pkg::TOL_W-1:0]           tol_r, tol_nxt;
  logic [lag_pkg::THETA_W-1:0]         theta_r, theta_nxt;
  logic [lag_pkg::GCNT_W-1:0]          used_r, used_nxt;
  logic [lag_pkg::GCNT_W-1:0]          g_r, g_nxt;
  logic [lag_pkg::CNT_W-1:0]           n_r, n_nxt;
  logic [lag_pkg::AEXT_W-1:0]          a_r, a_nxt;
  logic                                b_r, b_nxt;
  lag_pkg::num_t                       prod_r, prod_nxt;
  lag_pkg::out_item_t                  res_r, res_nxt;
  logic                                out_valid_r, out_valid_nxt;
  lag_pkg::out_item_t                  out_data_r, out_data_nxt;

  logic                                ram_we;
  logic [lag_pkg::GIDX_W-1:0]          ram_wr_addr;
  lag_pkg::grp_ent_t                   ram_wr_ent;
  logic [lag_pkg::GIDX_W-1:0]          ram_rd_addr;
  logic [ENT_W-1:0]                    ram_rd_data;
  lag_pkg::grp_ent_t                   ent;

  lag_pkg::div_req_t                   div_req;
  lag_pkg::div_rsp_t                   div_rsp;

  logic [lag_pkg::THETA_W-1:0]         ang_diff;
  logic                                theta_gt;
  logic                                hit_direct;
  logic                                hit_wrap;
  logic [lag_pkg::GCNT_W-1:0]          g_inc;
  logic                                in_xfer;
  logic                                out_xfer;

  lag_ram #(
    .WIDTH (ENT_W),
    .DEPTH (lag_pkg::MAX_GROUPS)
  ) u_grp_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_ent),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  lag_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign ent      = lag_pkg::grp_ent_t'(ram_rd_data);
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign g_inc    = g_r + lag_pkg::GCNT_W'(1);

  // Angular distance to the group under test; the wrap test looks for a
  // distance close to pi, which means the two lines are nearly parallel.
  always_comb begin
    theta_gt   = (theta_r > ent.mean);
    ang_diff   = theta_gt ? (theta_r - ent.mean) : (ent.mean - theta_r);
    hit_direct = (ang_diff < lag_pkg::THETA_W'(tol_r));
    hit_wrap   = ({1'b0, ang_diff} > (lag_pkg::PI_UNITS - lag_pkg::AEXT_W'(tol_r)));
  end

  always_comb begin
    state_nxt     = state_r;
    tol_nxt       = cfg_wr_en ? cfg_wr_data : tol_r;
    theta_nxt     = theta_r;
    used_nxt      = used_r;
    g_nxt         = g_r;
    n_nxt         = n_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    ram_we        = 1'b0;
    ram_wr_addr   = g_r[lag_pkg::GIDX_W-1:0];
    ram_wr_ent    = '0;
    ram_rd_addr   = g_r[lag_pkg::GIDX_W-1:0];

    div_req.start = 1'b0;
    div_req.num   = prod_r + lag_pkg::num_t'(theta_r)
                    + (b_r ? lag_pkg::num_t'(lag_pkg::PI_UNITS) : '0);
    div_req.den   = lag_pkg::den_t'(n_r) + lag_pkg::den_t'(1);

    unique case (state_r)
      ST_IDLE: begin
        ram_rd_addr = '0;
        if (in_xfer) begin
          theta_nxt = in_data.theta;
          g_nxt     = '0;
          if (in_data.frame_start) begin
            used_nxt = '0;
          end
          if (in_data.frame_start || (used_r == '0)) begin
            state_nxt = ST_NEW;
          end else begin
            state_nxt = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        // Fetch the next entry while this one is tested.
        ram_rd_addr = g_inc[lag_pkg::GIDX_W-1:0];
        n_nxt       = ent.cnt;
        if (hit_direct || hit_wrap) begin
          // Across the wrap, pi is taken off the larger angle. Both cases
          // are shifted up by (n+1)*pi so the dividend stays non-negative;
          // the low 16 quotient bits are then the wrapped mean.
          a_nxt     = (!hit_direct && theta_gt) ? ({1'b0, ent.mean} + lag_pkg::PI_UNITS)
                                                : {1'b0, ent.mean};
          b_nxt     = !hit_direct && !theta_gt;
          state_nxt = ST_MUL;
        end else if (g_inc == used_r) begin
          state_nxt = ST_NEW;
        end else begin
          g_nxt = g_inc;
        end
      end
      ST_MUL: begin
        prod_nxt  = n_r * a_r;
        state_nxt = ST_START;
      end
      ST_START: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          ram_we          = 1'b1;
          ram_wr_ent.mean = div_rsp.quo[lag_pkg::THETA_W-1:0];
          ram_wr_ent.cnt  = (n_r == lag_pkg::COUNT_MAX) ? n_r
                                                        : n_r + lag_pkg::CNT_W'(1);
          res_nxt.group_index = lag_pkg::grp_idx_t'(g_r);
          res_nxt.new_group   = 1'b0;
          res_nxt.dropped     = 1'b0;
          res_nxt.group_mean  = ram_wr_ent.mean;
          res_nxt.group_size  = ram_wr_ent.cnt;
          state_nxt           = ST_EMIT;
        end
      end
      ST_NEW: begin
        if (used_r < lag_pkg::GROUPS_LIMIT) begin
          ram_we              = 1'b1;
          ram_wr_addr         = used_r[lag_pkg::GIDX_W-1:0];
          ram_wr_ent.mean     = theta_r;
          ram_wr_ent.cnt      = lag_pkg::CNT_W'(1);
          used_nxt            = used_r + lag_pkg::GCNT_W'(1);
          res_nxt.group_index = lag_pkg::grp_idx_t'(used_r);
          res_nxt.new_group   = 1'b1;
          res_nxt.dropped     = 1'b0;
          res_nxt.group_mean  = theta_r;
          res_nxt.group_size  = lag_pkg::CNT_W'(1);
        end else begin
          res_nxt         = '0;
          res_nxt.dropped = 1'b1;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // The output register is free when empty or being drained now.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tol_r       <= lag_pkg::TOL_RESET;
      used_r      <= '0;
      g_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tol_r       <= tol_nxt;
      used_r      <= used_nxt;
      g_r         <= g_nxt;
      out_valid_r <= out_valid_nxt;
    end
    theta_r    <= theta_nxt;
    n_r        <= n_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= lag_pkg::GROUPS_LIMIT)
    else $error("group count exceeds the table size");

  a_test_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEST) |-> (g_r < used_r))
    else $error("search index beyond the open groups");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the division phase");

  a_new_group_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NEW && used_r < lag_pkg::GROUPS_LIMIT)
      |=> (used_r == $past(used_r) + lag_pkg::GCNT_W'(1)))
    else $error("opening a group did not advance the group count");

  a_emit_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && (!out_valid_r || !out_stall))
      |=> (out_valid_r && out_data_r == $past(res_r)))
    else $error("output register not loaded with the finished result");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Tracks the open groups exactly as the block should and holds the outcome
  // expected for every line transfer that is still in flight.
  class angle_group_book;
    localparam longint PI_ANGLE = 65536;

    int                          tol;
    int                          used;
    logic [lag_pkg::THETA_W-1:0] means[lag_pkg::MAX_GROUPS];
    logic [lag_pkg::CNT_W-1:0]   counts[lag_pkg::MAX_GROUPS];
    lag_pkg::out_item_t          outcomes[$];
    int                          errors;

    function new();
      tol    = int'(lag_pkg::TOL_RESET);
      used   = 0;
      errors = 0;
    endfunction

    function int pending();
      return outcomes.size();
    endfunction

    function void add_line(lag_pkg::in_item_t ln);
      lag_pkg::out_item_t r;
      longint             th;
      longint             m;
      longint             n;
      longint             d;
      longint             num;
      longint             q;
      r  = '0;
      th = longint'(ln.theta);
      if (ln.frame_start) used = 0;
      for (int g = 0; g < used; g++) begin
        m = longint'(means[g]);
        n = longint'(counts[g]);
        d = th - m;
        if (d < 0) d = -d;
        if (d < tol) begin
          num = n * m + th;
        end else if (d > PI_ANGLE - tol) begin
          // Across the wrap, pi comes off the larger of the two angles.
          if (th > m) num = n * m + th - PI_ANGLE;
          else num = n * (m - PI_ANGLE) + th;
        end else begin
          continue;
        end
        q = (num >= 0) ? num / (n + 1) : -((-num + n) / (n + 1));
        if (q < 0) q += PI_ANGLE;
        means[g] = q[lag_pkg::THETA_W-1:0];
        if (counts[g] < lag_pkg::COUNT_MAX) counts[g]++;
        r.group_index = lag_pkg::grp_idx_t'(g);
        r.group_mean  = means[g];
        r.group_size  = counts[g];
        outcomes = {outcomes, r};
        return;
      end
      if (used < lag_pkg::MAX_GROUPS) begin
        means[used]   = ln.theta;
        counts[used]  = lag_pkg::CNT_W'(1);
        r.group_index = lag_pkg::grp_idx_t'(used);
        r.new_group   = 1'b1;
        r.group_mean  = ln.theta;
        r.group_size  = lag_pkg::CNT_W'(1);
        used++;
      end else begin
        r.dropped = 1'b1;
      end
      outcomes = {outcomes, r};
    endfunction

    function void check_result(lag_pkg::out_item_t got);
      lag_pkg::out_item_t want;
      if (outcomes.size() == 0) begin
        $error("unexpected result transfer: index %0d mean %0d size %0d",
               got.group_index, got.group_mean, got.group_size);
        errors++;
        return;
      end
      want = outcomes.pop_front();
      if (got.group_index !== want.group_index) begin
        $error("group_index: expected %0d, actual %0d", want.group_index, got.group_index);
        errors++;
      end
      if (got.new_group !== want.new_group) begin
        $error("new_group: expected %0d, actual %0d", want.new_group, got.new_group);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped: expected %0d, actual %0d", want.dropped, got.dropped);
        errors++;
      end
      if (got.group_mean !== want.group_mean) begin
        $error("group_mean: expected %0d, actual %0d", want.group_mean, got.group_mean);
        errors++;
      end
      if (got.group_size !== want.group_size) begin
        $error("group_size: expected %0d, actual %0d", want.group_size, got.group_size);
        errors++;
      end
    endfunction
  endclass

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  lag_pkg::in_item_t         in_data     = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  lag_pkg::out_item_t        out_data;
  logic                      cfg_wr_en   = 1'b0;
  logic [lag_pkg::TOL_W-1:0] cfg_wr_data = '0;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  angle_group_book book = new();

  line_angle_grouper_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_result(out_data);
  end

  // Receiver back-pressure in bursts of random length.
  initial begin : result_stall_gen
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else if (out_idle_pct > 0 && $urandom_range(1, 100) <= out_idle_pct) begin
        out_stall <= 1'b1;
        left = $urandom_range(0, 5);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happened,
  // with in_valid still high so that a following line can go back to back.
  task automatic send_line(input logic [lag_pkg::THETA_W-1:0] theta, input logic fs);
    lag_pkg::in_item_t ln;
    ln.theta       = theta;
    ln.frame_start = fs;
    if (in_idle_pct > 0 && $urandom_range(1, 100) <= in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ln;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.add_line(ln);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lag_pkg::TOL_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    book.tol = value;
  endtask

  // Frames of lines clustered around a few orientations, with some noise lines
  // and the odd frame restart in the middle.
  task automatic run_frames(input int n_lines);
    int                          sent;
    int                          flen;
    int                          nc;
    int                          k;
    int                          jit;
    logic [lag_pkg::THETA_W-1:0] centers[24];
    logic [lag_pkg::THETA_W-1:0] th;
    logic                        fs;
    sent = 0;
    while (sent < n_lines) begin
      flen = $urandom_range(1, 40);
      nc   = $urandom_range(1, 20);
      jit  = (book.tol == 0) ? 2 : book.tol;
      for (k = 0; k < nc; k++) begin
        case ($urandom_range(0, 3))
          0:       centers[k] = lag_pkg::THETA_W'($urandom_range(0, 400));
          1:       centers[k] = lag_pkg::THETA_W'(65535 - $urandom_range(0, 400));
          default: centers[k] = lag_pkg::THETA_W'($urandom);
        endcase
      end
      for (k = 0; k < flen && sent < n_lines; k++) begin
        if (k == 0) fs = ($urandom_range(0, 9) != 0);
        else fs = ($urandom_range(0, 49) == 0);
        if ($urandom_range(0, 4) == 0) begin
          th = lag_pkg::THETA_W'($urandom);
        end else begin
          th = centers[$urandom_range(0, nc - 1)]
               + lag_pkg::THETA_W'(int'($urandom_range(0, 2 * jit)) - jit);
        end
        send_line(th, fs);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Default tolerance: matches across the wrap in both directions.
    in_idle_pct  = 20;
    out_idle_pct = 20;
    send_line(16'd0, 1'b1);
    send_line(16'd65535, 1'b0);
    send_line(16'd0, 1'b0);
    send_line(16'd32768, 1'b0);
    send_line(16'd40049, 1'b0);
    send_line(16'd58254, 1'b1);

    // Zero tolerance: nothing matches, the table fills and lines drop.
    wait_drained();
    write_tolerance(0);
    send_line(16'd0, 1'b1);
    send_line(16'd0, 1'b0);
    send_line(16'd65535, 1'b0);
    for (int i = 0; i < 15; i++) send_line(lag_pkg::THETA_W'($urandom), 1'b0);

    // Widest tolerance: the gap between the direct and the wrap test.
    wait_drained();
    write_tolerance(32767);
    send_line(16'd0, 1'b1);
    send_line(16'd32767, 1'b0);
    send_line(16'd32766, 1'b0);
    send_line(16'd65535, 1'b0);

    // One group collects a long run of lines.
    wait_drained();
    write_tolerance(int'(lag_pkg::TOL_RESET));
    in_idle_pct  = 5;
    out_idle_pct = 5;
    send_line(16'd1000, 1'b1);
    for (int i = 0; i < 200; i++) begin
      send_line(lag_pkg::THETA_W'(980 + $urandom_range(0, 40)), 1'b0);
    end

    for (int p = 0; p < 7; p++) begin
      wait_drained();
      case (p)
        0:       write_tolerance(1);
        1:       write_tolerance(32767);
        2:       write_tolerance(0);
        3:       write_tolerance($urandom_range(1, 600));
        default: write_tolerance($urandom_range(0, 32767));
      endcase
      in_idle_pct  = 10 * $urandom_range(0, 4);
      out_idle_pct = 10 * $urandom_range(0, 4);
      run_frames(35);
    end

    wait_drained();
    write_tolerance($urandom_range(1000, 12000));
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_frames(50);

    wait_drained();
    repeat (60) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("[line_angle_grouper_core] OK");
    end else begin
      $display("[line_angle_grouper_core] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[line_angle_grouper_core] ERROR");
    $finish;
  end

endmodule

### line_angle_grouper_core.f
src/lag_pkg.sv
src/lag_ram.sv
src/lag_div.sv
src/line_angle_grouper_core.sv
sim/testbench.sv
